// ===== src/irpde_pkg.sv =====
// Shared types, frame geometry and symbol timing tables for the IR frame encoder.
// No dependencies; imported by every module of the block.
package irpde_pkg;

   localparam int SECTION1_BYTES = 8;
   localparam int SECTION2_BYTES = 8;
   localparam int SECTION3_BYTES = 19;
   localparam int FRAME_BYTES    = SECTION1_BYTES + SECTION2_BYTES + SECTION3_BYTES;
   localparam int POS_W          = 6;

   localparam int MARK_W  = 12;
   localparam int SPACE_W = 15;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Symbol sequence of one byte, in emit order
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_PRE_FIRST = 5'd0;
   localparam logic [STEP_W-1:0] STEP_PRE_LAST  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_LEADER    = 5'd6;
   localparam logic [STEP_W-1:0] STEP_BIT_FIRST = 5'd7;
   localparam logic [STEP_W-1:0] STEP_BIT_LAST  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_GAP       = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LEADER2   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_TERM      = 5'd17;

   localparam logic PROFILE_CAPTURED = 1'b0;
   localparam logic PROFILE_NOMINAL  = 1'b1;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       profile;
      logic       first;
      logic       gap;
      logic       term;
   } desc_type;

   typedef struct packed {
      logic [MARK_W-1:0]  mark;
      logic [SPACE_W-1:0] space;
   } sym_type;

   // Preamble symbols, same for both profiles
   localparam sym_type PREAMBLE_TAB [6] = '{
      '{mark: 12'd531, space: 15'd330},
      '{mark: 12'd510, space: 15'd356},
      '{mark: 12'd507, space: 15'd359},
      '{mark: 12'd504, space: 15'd362},
      '{mark: 12'd500, space: 15'd389},
      '{mark: 12'd474, space: 15'd25076}
   };

   function automatic sym_type sym_lookup(input logic [STEP_W-1:0] step,
                                          input logic              bit_val,
                                          input logic              profile);
      sym_type s;
      s = '{mark: 12'd0, space: 15'd0};
      case (step) inside
         [STEP_PRE_FIRST:STEP_PRE_LAST]: s = PREAMBLE_TAB[3'(step - STEP_PRE_FIRST)];
         STEP_LEADER, STEP_LEADER2: begin
            if (profile == PROFILE_NOMINAL) s = '{mark: 12'd3360, space: 15'd1760};
            else                            s = '{mark: 12'd3462, space: 15'd1728};
         end
         [STEP_BIT_FIRST:STEP_BIT_LAST]: begin
            if (profile == PROFILE_NOMINAL)
               s = bit_val ? '{mark: 12'd360, space: 15'd1370} : '{mark: 12'd360, space: 15'd520};
            else
               s = bit_val ? '{mark: 12'd438, space: 15'd1294} : '{mark: 12'd438, space: 15'd428};
         end
         STEP_GAP: begin
            if (profile == PROFILE_NOMINAL) s = '{mark: 12'd360, space: 15'd32300};
            else                            s = '{mark: 12'd437, space: 15'd2743};
         end
         STEP_TERM: begin
            if (profile == PROFILE_NOMINAL) s = '{mark: 12'd360, space: 15'd0};
            else                            s = '{mark: 12'd439, space: 15'd0};
         end
         default: s = '{mark: 12'd0, space: 15'd0};
      endcase
      return s;
   endfunction

endpackage

// ===== src/irpde_front.sv =====
// Front end: accepts payload bytes, tracks the byte position in the frame and
// tags each byte with preamble, gap and terminal flags. Uses irpde_pkg.
module irpde_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                profile,
   input  logic                queue_full,
   output logic                push,
   output irpde_pkg::desc_type push_desc
);
   import irpde_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             is_term;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign is_term    = pos_ff >= POS_W'(FRAME_BYTES - 1);

   always_comb begin
      push_desc.payload_byte = req_tdata;
      push_desc.profile      = profile;
      push_desc.first        = pos_ff == '0;
      push_desc.gap          = pos_ff == POS_W'(SECTION1_BYTES - 1) ||
                               pos_ff == POS_W'(SECTION1_BYTES + SECTION2_BYTES - 1);
      push_desc.term         = is_term;
   end

   always_comb begin
      pos_in = pos_ff;
      if (push) begin
         pos_in = is_term ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== src/irpde_queue.sv =====
// Short descriptor queue between front end and symbol sequencer.
// Uses irpde_pkg for the descriptor type and depth.
module irpde_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  irpde_pkg::desc_type push_desc,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output irpde_pkg::desc_type head_desc,
   output logic [irpde_pkg::QCNT_W-1:0] count
);
   import irpde_pkg::*;

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/irpde_back.sv =====
// Back end: steps through the symbols of the head descriptor into an output register,
// one per cycle unless rsp_tready stalls. Uses irpde_pkg for step codes and timing tables.
module irpde_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  irpde_pkg::desc_type head_desc,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [irpde_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);
   import irpde_pkg::*;

   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] cur_step, next_step;
   logic [2:0]        bit_idx;
   logic              is_last, emit;
   sym_type           sym;
   logic              out_valid_ff, out_valid_in;
   sym_type           out_sym_ff, out_sym_in;
   logic              out_last_ff, out_last_in;
   logic              out_end_ff, out_end_in;

   assign cur_step = active_ff ? step_ff
                               : (head_desc.first ? STEP_PRE_FIRST : STEP_BIT_FIRST);
   assign bit_idx  = 3'(cur_step - STEP_BIT_FIRST);
   assign sym      = sym_lookup(cur_step, head_desc.payload_byte[bit_idx], head_desc.profile);
   assign emit     = head_valid && (!out_valid_ff || rsp_tready);
   assign pop      = emit && is_last;

   always_comb begin
      is_last = 1'b0;
      case (cur_step)
         STEP_BIT_LAST: is_last = !head_desc.gap && !head_desc.term;
         STEP_LEADER2:  is_last = !head_desc.term;
         STEP_TERM:     is_last = 1'b1;
         default:       is_last = 1'b0;
      endcase
   end

   always_comb begin
      next_step = cur_step + 1'b1;
      case (cur_step)
         STEP_BIT_LAST: next_step = head_desc.gap ? STEP_GAP : STEP_TERM;
         STEP_LEADER2:  next_step = STEP_TERM;
         default:       next_step = cur_step + 1'b1;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (emit) begin
         active_in    = !is_last;
         step_in      = next_step;
         out_valid_in = 1'b1;
         out_sym_in   = sym;
         out_last_in  = is_last;
         out_end_in   = cur_step == STEP_TERM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - MARK_W - SPACE_W){1'b0}},
                        out_sym_ff.space, out_sym_ff.mark};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

endmodule

// ===== src/ir_pulse_distance_frame_encoder.sv =====
// Top level of the IR pulse-distance frame encoder: front end, descriptor
// queue and symbol sequencer. Uses irpde_pkg.
//
// Each payload byte yields 8 bit symbols (LSB first), plus 7 preamble/leader
// symbols on the first byte of a frame, a gap and leader after the last byte
// of sections one and two, and a terminal mark after the last byte of the
// frame: 8 to 15 symbols per byte with the section sizes in irpde_pkg. The
// sequencer emits one symbol per clock unless rsp_tready stalls the output;
// the two-entry queue lets the next bytes be taken while symbols still go out.
// timing_profile is sampled when a byte is accepted.
module ir_pulse_distance_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] mark_ticks, [26:12] space_ticks, rest zero
   output logic        rsp_tlast,   // last_of_byte
   output logic        rsp_tuser,   // frame_end
   input  logic        csr_we,
   input  logic        csr_wdata    // timing_profile
);
   import irpde_pkg::*;

   logic              profile_ff, profile_in;
   logic              push, pop, queue_full, head_valid;
   desc_type          push_desc, head_desc;
   logic [QCNT_W-1:0] queue_count;

   assign profile_in = csr_we ? csr_wdata : profile_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= PROFILE_NOMINAL;
      end else begin
         profile_ff <= profile_in;
      end
   end

   irpde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .profile    (profile_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   irpde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .count      (queue_count)
   );

   irpde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The terminal mark always closes its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without last_of_byte");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_tready)
      else $error("byte taken while queue full");

endmodule

// ===== dv/tb_ir_pulse_distance_frame_encoder.sv =====
// Self-checking testbench for ir_pulse_distance_frame_encoder: drives payload bytes,
// predicts every mark/space symbol and compares the symbol stream field by field.
// Depends on irpde_pkg and the encoder RTL only.
module tb_ir_pulse_distance_frame_encoder;
   import irpde_pkg::*;

   typedef struct {
      logic [MARK_W-1:0]  mark;
      logic [SPACE_W-1:0] space;
      logic               last_of_byte;
      logic               frame_end;
   } ir_symbol_type;

   // Frame model: tracks byte position and timing profile, queues expected symbols
   class symbol_scoreboard;
      ir_symbol_type     expected_symbols[$];
      logic              profile = PROFILE_NOMINAL;
      logic [POS_W-1:0]  byte_pos = '0;
      int                bytes_noted = 0;
      int                symbols_checked = 0;
      int                frames_closed = 0;
      int                mismatches = 0;

      function void set_profile(logic value);
         profile = value;
      endfunction

      function int pending();
         return expected_symbols.size();
      endfunction

      function void push_symbol(int m, int s, logic lob, logic fe);
         ir_symbol_type sym;
         sym.mark = m[MARK_W-1:0];
         sym.space = s[SPACE_W-1:0];
         sym.last_of_byte = lob;
         sym.frame_end = fe;
         expected_symbols.push_back(sym);
      endfunction

      function void note_byte(logic [7:0] payload);
         int  pre_mark[6];
         int  pre_space[6];
         int  lead_m, lead_s, gap_m, gap_s, bit_m, zero_s, one_s, term_m;
         bit  sect_end;
         bit  frame_last;
         pre_mark  = '{531, 510, 507, 504, 500, 474};
         pre_space = '{330, 356, 359, 362, 389, 25076};
         if (profile == PROFILE_NOMINAL) begin
            lead_m = 3360; lead_s = 1760; gap_m = 360; gap_s = 32300;
            bit_m = 360; zero_s = 520; one_s = 1370; term_m = 360;
         end else begin
            lead_m = 3462; lead_s = 1728; gap_m = 437; gap_s = 2743;
            bit_m = 438; zero_s = 428; one_s = 1294; term_m = 439;
         end
         sect_end = (byte_pos == SECTION1_BYTES - 1) ||
                    (byte_pos == SECTION1_BYTES + SECTION2_BYTES - 1);
         frame_last = (byte_pos >= FRAME_BYTES - 1);
         bytes_noted++;

         if (byte_pos == 0) begin
            for (int i = 0; i < 6; i++) push_symbol(pre_mark[i], pre_space[i], 1'b0, 1'b0);
            push_symbol(lead_m, lead_s, 1'b0, 1'b0);
         end
         // LSB first; bit 7 closes the byte unless a gap or terminal follows
         for (int i = 0; i < 8; i++)
            push_symbol(bit_m, payload[i] ? one_s : zero_s,
                        (i == 7) && !sect_end && !frame_last, 1'b0);
         if (sect_end) begin
            push_symbol(gap_m, gap_s, 1'b0, 1'b0);
            push_symbol(lead_m, lead_s, !frame_last, 1'b0);
         end
         if (frame_last) begin
            push_symbol(term_m, 0, 1'b1, 1'b1);
            frames_closed++;
            byte_pos = '0;
         end else begin
            byte_pos = byte_pos + 1'b1;
         end
      endfunction

      function void check_symbol(logic [31:0] data, logic tlast, logic tuser);
         ir_symbol_type want;
         if (expected_symbols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected symbol: mark=%0d space=%0d last=%b end=%b", $realtime,
                        data[11:0], data[26:12], tlast, tuser);
            return;
         end
         want = expected_symbols.pop_front();
         symbols_checked++;
         if (data[11:0] !== want.mark || data[26:12] !== want.space || data[31:27] !== 5'd0 ||
             tlast !== want.last_of_byte || tuser !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] symbol %0d: exp mark=%0d space=%0d last=%b end=%b",
                        $realtime, symbols_checked, want.mark, want.space, want.last_of_byte,
                        want.frame_end);
               $display("   got data=%h mark=%0d space=%0d last=%b end=%b",
                        data, data[11:0], data[26:12], tlast, tuser);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   symbol_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_cycles = 0;

   ir_pulse_distance_frame_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Symbol sink: check accepted symbols, then pick next ready (long hold wins)
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_symbol(rsp_tdata, rsp_tlast, rsp_tuser);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] payload);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= payload;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(payload);
   endtask

   // Leaves req_tvalid high after the last item; wait_drained drops it
   task automatic send_random_bytes(input int count);
      logic [7:0] payload;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: payload = 8'h00;
            1: payload = 8'hFF;
            default: payload = 8'($urandom_range(0, 255));
         endcase
         send_byte(payload);
      end
   endtask

   // Hold input until every queued symbol is out, then let the pipeline settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_profile(input logic value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_profile(value);
   endtask

   initial begin
      logic [7:0] directed_bytes[18];
      sb = new;
      directed_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                         8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3,
                         8'h12, 8'h34};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset profile: first frame opening, both section ends
      send_idle_pct = 26;
      recv_idle_pct = 58;
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_drained();

      // Switch to captured timing mid-frame
      write_profile(PROFILE_CAPTURED);
      send_random_bytes(110);
      wait_drained();

      write_profile(PROFILE_NOMINAL);
      send_idle_pct = 58;
      recv_idle_pct = 26;
      rsp_hold_cycles = 300;
      send_random_bytes(100);
      wait_drained();

      write_profile(PROFILE_CAPTURED);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_bytes(51);
      wait_drained();
      write_profile(PROFILE_NOMINAL);
      send_random_bytes(51);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("Encoded %0d bytes into %0d symbols, %0d complete frames,", sb.bytes_noted,
               sb.symbols_checked, sb.frames_closed);
      $display("both timing profiles, three idle mixes and a long sink stall; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== ir_pulse_distance_frame_encoder.f =====
src/irpde_pkg.sv
src/irpde_front.sv
src/irpde_queue.sv
src/irpde_back.sv
src/ir_pulse_distance_frame_encoder.sv
dv/tb_ir_pulse_distance_frame_encoder.sv
